[rtl/core/pss_pkg.sv]
// Package for the positional sequence store: sizes, operation and status codes,
// and the beat, result and element RAM request types.
// Depends on nothing; every other file of the block imports it.
package pss_pkg;

  localparam int CAPACITY = 64;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int KIND_W   = 4;
  localparam int VAL_W    = 32;
  localparam int POS_W    = 7;
  localparam int STAT_W   = 3;

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  // Operation codes
  localparam logic [KIND_W-1:0] K_PUSH_BACK  = 4'd0;
  localparam logic [KIND_W-1:0] K_PUSH_FRONT = 4'd1;
  localparam logic [KIND_W-1:0] K_INSERT_AT  = 4'd2;
  localparam logic [KIND_W-1:0] K_DEL_FRONT  = 4'd3;
  localparam logic [KIND_W-1:0] K_DEL_BACK   = 4'd4;
  localparam logic [KIND_W-1:0] K_DEL_AT     = 4'd5;
  localparam logic [KIND_W-1:0] K_READ_AT    = 4'd6;
  localparam logic [KIND_W-1:0] K_REVERSE    = 4'd7;
  localparam logic [KIND_W-1:0] K_CLEAR      = 4'd8;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK    = 3'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 3'd1;
  localparam logic [STAT_W-1:0] ST_NONE  = 3'd2;
  localparam logic [STAT_W-1:0] ST_FULL  = 3'd3;
  localparam logic [STAT_W-1:0] ST_NOREV = 3'd4;

  typedef struct packed {
    logic [KIND_W-1:0]       kind;
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        position;
  } cmd_t;

  typedef struct packed {
    logic [STAT_W-1:0]       status;
    logic signed [VAL_W-1:0] read_value;
    logic [CNT_W-1:0]        count;
  } rsp_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [VAL_W-1:0]  wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

endpackage

[rtl/core/pss_mem.sv]
// Element RAM of the positional sequence store: one write port, one read port,
// read data registered, valid in the cycle after the request. Depends on pss_pkg.
module pss_mem (
  input  logic                     clk,
  input  pss_pkg::mem_req_t        req,
  output logic [pss_pkg::VAL_W-1:0] rdata
);
  import pss_pkg::*;

  logic [VAL_W-1:0] store [CAPACITY];

  always_ff @(posedge clk) begin
    if (req.we) begin
      store[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata <= store[req.raddr];
    end
  end

endmodule

[rtl/core/pss_ctrl.sv]
// Sequencer of the positional sequence store: decodes one beat, walks the
// element RAM to shift, swap or read, and hands over one result. Depends on pss_pkg.
module pss_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cmd_take,
  input  pss_pkg::cmd_t             cmd,
  input  logic                      rsp_free,
  input  logic [pss_pkg::VAL_W-1:0] rdata,
  output logic                      busy,
  output logic                      done,
  output pss_pkg::rsp_t             rsp,
  output pss_pkg::mem_req_t         mem_req
);
  import pss_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DISP    = 4'd1;
  localparam logic [3:0] S_INS     = 4'd2;
  localparam logic [3:0] S_INS_PUT = 4'd3;
  localparam logic [3:0] S_DEL     = 4'd4;
  localparam logic [3:0] S_RD      = 4'd5;
  localparam logic [3:0] S_REV_HI  = 4'd6;
  localparam logic [3:0] S_REV_WLO = 4'd7;
  localparam logic [3:0] S_REV_WHI = 4'd8;
  localparam logic [3:0] S_FIN     = 4'd9;

  logic [3:0]        state, state_next;
  logic [KIND_W-1:0] kind;
  logic [VAL_W-1:0]  value;
  logic [POS_W-1:0]  pos;
  logic [CNT_W-1:0]  count, count_next;
  logic [ADDR_W-1:0] cur, cur_next;
  logic [ADDR_W-1:0] hi, hi_next;
  logic [ADDR_W-1:0] target, target_next;
  logic [VAL_W-1:0]  tmp, tmp_next;
  logic [STAT_W-1:0] status, status_next;
  logic [VAL_W-1:0]  rd, rd_next;

  logic [ADDR_W-1:0] cnt_m1;
  logic [ADDR_W-1:0] pos_idx;
  logic [ADDR_W-1:0] ins_idx;
  logic [ADDR_W-1:0] del_idx;

  assign cnt_m1  = ADDR_W'(count - CNT_W'(1));
  assign pos_idx = (pos == '0) ? '0 : ADDR_W'(pos - POS_W'(1));

  always_comb begin
    if (kind == K_PUSH_BACK) begin
      ins_idx = count[ADDR_W-1:0];
    end else if (kind == K_PUSH_FRONT) begin
      ins_idx = '0;
    end else if (pos > POS_W'(count)) begin
      ins_idx = count[ADDR_W-1:0];
    end else if (pos <= POS_W'(1)) begin
      ins_idx = '0;
    end else begin
      ins_idx = pos_idx;
    end
  end

  always_comb begin
    if (kind == K_DEL_FRONT) begin
      del_idx = '0;
    end else if (kind == K_DEL_BACK) begin
      del_idx = cnt_m1;
    end else begin
      del_idx = pos_idx;
    end
  end

  always_comb begin
    state_next  = state;
    count_next  = count;
    cur_next    = cur;
    hi_next     = hi;
    target_next = target;
    tmp_next    = tmp;
    status_next = status;
    rd_next     = rd;
    mem_req     = '0;
    done        = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (cmd_take) begin
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        status_next = ST_OK;
        rd_next     = '0;
        state_next  = S_FIN;
        case (kind) inside
          K_PUSH_BACK, K_PUSH_FRONT, K_INSERT_AT: begin
            if (count == CAP_CNT) begin
              status_next = ST_FULL;
            end else if (ins_idx == count[ADDR_W-1:0]) begin
              mem_req.we    = 1'b1;
              mem_req.waddr = ins_idx;
              mem_req.wdata = value;
              count_next    = count + CNT_W'(1);
            end else begin
              // open the gap from the top down
              cur_next      = count[ADDR_W-1:0];
              target_next   = ins_idx;
              mem_req.re    = 1'b1;
              mem_req.raddr = cnt_m1;
              state_next    = S_INS;
            end
          end
          K_DEL_FRONT, K_DEL_BACK, K_DEL_AT: begin
            if (count == '0) begin
              status_next = ST_EMPTY;
            end else if (kind == K_DEL_AT && pos > POS_W'(count)) begin
              status_next = ST_NONE;
            end else if (del_idx == cnt_m1) begin
              count_next = count - CNT_W'(1);
            end else begin
              cur_next      = del_idx;
              mem_req.re    = 1'b1;
              mem_req.raddr = del_idx + ADDR_W'(1);
              state_next    = S_DEL;
            end
          end
          K_READ_AT: begin
            if (count == '0) begin
              status_next = ST_EMPTY;
            end else if (pos > POS_W'(count)) begin
              status_next = ST_NONE;
            end else begin
              mem_req.re    = 1'b1;
              mem_req.raddr = pos_idx;
              state_next    = S_RD;
            end
          end
          K_REVERSE: begin
            if (count < CNT_W'(2)) begin
              status_next = ST_NOREV;
            end else begin
              cur_next      = '0;
              hi_next       = cnt_m1;
              mem_req.re    = 1'b1;
              mem_req.raddr = '0;
              state_next    = S_REV_HI;
            end
          end
          K_CLEAR: begin
            count_next = '0;
          end
          default: begin
          end
        endcase
      end
      S_INS: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = cur;
        mem_req.wdata = rdata;
        if (cur - ADDR_W'(1) == target) begin
          state_next = S_INS_PUT;
        end else begin
          cur_next      = cur - ADDR_W'(1);
          mem_req.re    = 1'b1;
          mem_req.raddr = cur - ADDR_W'(2);
        end
      end
      S_INS_PUT: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = target;
        mem_req.wdata = value;
        count_next    = count + CNT_W'(1);
        state_next    = S_FIN;
      end
      S_DEL: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = cur;
        mem_req.wdata = rdata;
        if (cur + ADDR_W'(1) == cnt_m1) begin
          count_next = count - CNT_W'(1);
          state_next = S_FIN;
        end else begin
          cur_next      = cur + ADDR_W'(1);
          mem_req.re    = 1'b1;
          mem_req.raddr = cur + ADDR_W'(2);
        end
      end
      S_RD: begin
        rd_next    = rdata;
        state_next = S_FIN;
      end
      S_REV_HI: begin
        tmp_next      = rdata;
        mem_req.re    = 1'b1;
        mem_req.raddr = hi;
        state_next    = S_REV_WLO;
      end
      S_REV_WLO: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = cur;
        mem_req.wdata = rdata;
        state_next    = S_REV_WHI;
      end
      S_REV_WHI: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = hi;
        mem_req.wdata = tmp;
        if (cur + ADDR_W'(1) < hi - ADDR_W'(1)) begin
          cur_next      = cur + ADDR_W'(1);
          hi_next       = hi - ADDR_W'(1);
          mem_req.re    = 1'b1;
          mem_req.raddr = cur + ADDR_W'(1);
          state_next    = S_REV_HI;
        end else begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (rsp_free) begin
          done       = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take) begin
      kind  <= cmd.kind;
      value <= cmd.value;
      pos   <= cmd.position;
    end
    cur    <= cur_next;
    hi     <= hi_next;
    target <= target_next;
    tmp    <= tmp_next;
    status <= status_next;
    rd     <= rd_next;
  end

  assign busy           = (state != S_IDLE);
  assign rsp.status     = status;
  assign rsp.read_value = rd;
  assign rsp.count      = count;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CAP_CNT)
    else $error("element count above capacity");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE || state == S_FIN) |-> !mem_req.we)
    else $error("element RAM written outside an operation");

  a_rw_apart: assert property (@(posedge clk) disable iff (rst)
    (mem_req.we && mem_req.re) |-> (mem_req.waddr != mem_req.raddr))
    else $error("read and write to the same entry in one cycle");

  a_done_free: assert property (@(posedge clk) disable iff (rst)
    done |-> rsp_free)
    else $error("result handed over into an occupied output register");

  a_take_idle: assert property (@(posedge clk) disable iff (rst)
    cmd_take |=> (state == S_DISP))
    else $error("accepted beat not dispatched");

endmodule

[rtl/core/positional_sequence_store_core.sv]
// Top level of the positional sequence store: command and result channels,
// output register, sequencer and element RAM. Depends on pss_pkg, pss_mem, pss_ctrl.
//
//   channel | direction | handshake            | beat
//   --------+-----------+----------------------+---------------------------------
//   cmd     | in        | cmd_valid, cmd_stall | kind, value, position  (cmd_t)
//   rsp     | out       | rsp_valid, rsp_stall | status, read_value, count (rsp_t)
//
// One beat at a time. A read fetches one entry; insert shifts the elements at and
// above the insertion point one entry higher, top down, and then places the value;
// delete shifts the elements above the deleted one one entry lower; reverse swaps
// pairs from both ends inward, reading both and then writing each in turn through
// the single write port of the element RAM. Reset is synchronous and clears the
// state, the count and the result valid; the RAM needs no clearing pass. A stalled
// result waits in the output register while the next beat is already being worked on.
module positional_sequence_store_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_stall,
  input  pss_pkg::cmd_t  cmd,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output pss_pkg::rsp_t  rsp
);
  import pss_pkg::*;

  logic             busy;
  logic             done;
  logic             cmd_take;
  logic             rsp_free;
  rsp_t             result;
  mem_req_t         mem_req;
  logic [VAL_W-1:0] rdata;

  // Take a beat only when the sequencer is idle.
  assign cmd_stall = busy;
  assign cmd_take  = cmd_valid && !busy;

  // The output register is free when empty or being drained this cycle.
  assign rsp_free = !rsp_valid || !rsp_stall;

  pss_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cmd_take (cmd_take),
    .cmd      (cmd),
    .rsp_free (rsp_free),
    .rdata    (rdata),
    .busy     (busy),
    .done     (done),
    .rsp      (result),
    .mem_req  (mem_req)
  );

  pss_mem u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (rdata)
  );

  // Output register: load on done, drop the valid once taken, hold while stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (done) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      rsp <= result;
    end
  end

endmodule
